// ----- design/dra_pkg.sv -----
// ----------------------------------------------------------------------------
// dra_pkg: shared types and constants of the draw event detector
// Register indexes, controller states and the command/status structs.
// ----------------------------------------------------------------------------
package dra_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int DATA_W        = 32;
    localparam int THR_W         = 31;
    localparam int DT_W          = 16;
    localparam int IDX_W         = 3;

    localparam logic [IDX_W-1:0] REG_ON_DROP    = 3'd0;
    localparam logic [IDX_W-1:0] REG_OFF_DROP   = 3'd1;
    localparam logic [IDX_W-1:0] REG_SLOPE_RISE = 3'd2;
    localparam logic [IDX_W-1:0] REG_TAU        = 3'd3;
    localparam logic [IDX_W-1:0] REG_ON_DEB     = 3'd4;
    localparam logic [IDX_W-1:0] REG_OFF_DEB    = 3'd5;
    localparam logic [IDX_W-1:0] REG_MAX_DRAW   = 3'd6;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EVAL,
        ST_MUL,
        ST_DIV,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic load;      // capture sample and run the tests
        logic mul;       // form the two products
        logic div_start; // load the divider
        logic div_step;  // one quotient bit of both divides
        logic commit;    // write baselines
    } t_cmd;

    typedef struct packed {
        logic div_last;
        logic tracking;
    } t_status;

endpackage

// ----- design/dra_if.sv -----
// ----------------------------------------------------------------------------
// dra_stream_if: valid/ready channel
// Carries one payload of the given width.
// ----------------------------------------------------------------------------
interface dra_stream_if #(parameter int W = 1) (input logic i_clk);
    logic         valid;
    logic         ready;
    logic [W-1:0] data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ----- design/dra_datapath.sv -----
// ----------------------------------------------------------------------------
// dra_datapath: baselines, timers, flags and the two lockstep restoring dividers
// Both baseline updates are divided in lockstep, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module dra_datapath (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  dra_pkg::t_cmd                 i_cmd,
    output dra_pkg::t_status              o_status,
    input  logic [dra_pkg::DATA_W-1:0]    i_dist,
    input  logic [dra_pkg::DATA_W-1:0]    i_slope,
    input  logic [dra_pkg::DT_W-1:0]      i_dt,
    input  logic                          i_en,
    input  logic [dra_pkg::THR_W-1:0]     i_on_drop,
    input  logic [dra_pkg::THR_W-1:0]     i_off_drop,
    input  logic [dra_pkg::THR_W-1:0]     i_slope_rise,
    input  logic [dra_pkg::DATA_W-1:0]    i_tau,
    input  logic [dra_pkg::DATA_W-1:0]    i_on_deb,
    input  logic [dra_pkg::DATA_W-1:0]    i_off_deb,
    input  logic [dra_pkg::DATA_W-1:0]    i_max_draw,
    output logic                          o_active,
    output logic                          o_lockout
);
    import dra_pkg::*;

    // difference up to 33 bits signed, product up to 49 bits magnitude
    localparam int PW = 49;
    localparam int DW = 33;
    localparam int CW = 6;

    logic               r_active, r_lockout, r_seeded, r_track;
    logic signed [33:0] r_bd, r_bs;
    logic [31:0]        r_hit, r_clr, r_drw;
    logic signed [33:0] r_x, r_g;
    logic [DT_W-1:0]    r_dt;
    logic [DW-1:0]      r_den;
    logic               r_den_zero;
    logic [PW-1:0]      r_pd, r_ps;   // magnitudes of products
    logic               r_nd, r_ns;   // product signs
    logic [PW-1:0]      r_qd, r_qs;
    logic [DW-1:0]      r_remd, r_rems;
    logic [CW-1:0]      r_cnt;

    logic signed [33:0] bd0, bs0, dd, ds;
    logic               x_hit, g_hit, x_clr, g_clr;
    logic [32:0]        s_hit, s_clr, s_drw;
    logic [31:0]        hit_n, clr_n, drw_n;
    logic [33:0]        ad, as_;
    logic [DW+1:0]      trd, trs;
    logic [DW:0]        rd_sh, rs_sh;

    function automatic logic [31:0] sat(input logic [32:0] s);
        return s[32] ? 32'hFFFF_FFFF : s[31:0];
    endfunction

    always_comb begin
        bd0   = r_seeded ? r_bd : 34'(signed'(i_dist));
        bs0   = r_seeded ? r_bs : 34'(signed'(i_slope));
        x_hit = 34'(signed'(i_dist)) < bd0 - 34'(signed'({1'b0, i_on_drop}));
        g_hit = 34'(signed'(i_slope)) > bs0 + 34'(signed'({1'b0, i_slope_rise}));
        x_clr = 34'(signed'(i_dist)) > bd0 - 34'(signed'({1'b0, i_off_drop}));
        g_clr = (34'(signed'(i_slope)) <<< 1) <
                (bs0 <<< 1) + 34'(signed'({1'b0, i_slope_rise}));
        s_hit = {1'b0, r_hit} + 33'(i_dt);
        s_clr = {1'b0, r_clr} + 33'(i_dt);
        s_drw = {1'b0, r_drw} + 33'(i_dt);
        hit_n = sat(s_hit);
        clr_n = (x_clr && g_clr) ? sat(s_clr) : 32'd0;
        drw_n = sat(s_drw);
        dd    = r_x - r_bd;
        ds    = r_g - r_bs;
        ad    = dd[33] ? 34'(-dd) : dd;
        as_   = ds[33] ? 34'(-ds) : ds;
        rd_sh = {r_remd, r_qd[PW-1]};
        rs_sh = {r_rems, r_qs[PW-1]};
        trd   = {1'b0, rd_sh} - {2'b00, r_den};
        trs   = {1'b0, rs_sh} - {2'b00, r_den};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0; r_lockout <= 1'b0; r_seeded <= 1'b0; r_track <= 1'b0;
            r_bd <= '0; r_bs <= '0; r_hit <= '0; r_clr <= '0; r_drw <= '0;
            r_cnt <= '0;
        end else begin
            if (i_cmd.load) begin
                r_x   <= 34'(signed'(i_dist));
                r_g   <= 34'(signed'(i_slope));
                r_dt  <= i_dt;
                r_den <= DW'(i_tau) + DW'(i_dt);
                r_den_zero <= (i_tau == '0) && (i_dt == '0);
                r_track <= 1'b0;
                if (!i_en) begin
                    r_active <= 1'b0; r_lockout <= 1'b0; r_seeded <= 1'b0;
                    r_bd <= '0; r_bs <= '0; r_hit <= '0; r_clr <= '0; r_drw <= '0;
                end else begin
                    r_seeded <= 1'b1;
                    r_bd <= bd0;
                    r_bs <= bs0;
                    if (!r_active) begin
                        r_track <= 1'b1;
                        if (r_lockout) begin
                            if (x_clr && g_clr) r_lockout <= 1'b0;
                        end else if (x_hit || g_hit) begin
                            r_hit <= hit_n;
                            if (hit_n >= i_on_deb) begin
                                r_active <= 1'b1;
                                r_drw <= '0;
                                r_clr <= '0;
                            end
                        end else begin
                            r_hit <= '0;
                        end
                    end else begin
                        r_drw <= drw_n;
                        r_clr <= clr_n;
                        if (drw_n >= i_max_draw) begin
                            r_active <= 1'b0; r_lockout <= 1'b1; r_hit <= '0;
                        end else if (clr_n >= i_off_deb) begin
                            r_active <= 1'b0; r_hit <= '0;
                        end
                    end
                end
            end
            if (i_cmd.mul) begin
                r_pd <= PW'(ad) * PW'(r_dt);
                r_ps <= PW'(as_) * PW'(r_dt);
                r_nd <= dd[33];
                r_ns <= ds[33];
            end
            if (i_cmd.div_start) begin
                r_qd <= r_pd; r_qs <= r_ps;
                r_remd <= '0; r_rems <= '0;
                r_cnt <= '0;
            end
            if (i_cmd.div_step) begin
                r_remd <= trd[DW+1] ? rd_sh[DW-1:0] : trd[DW-1:0];
                r_rems <= trs[DW+1] ? rs_sh[DW-1:0] : trs[DW-1:0];
                r_qd <= {r_qd[PW-2:0], ~trd[DW+1]};
                r_qs <= {r_qs[PW-2:0], ~trs[DW+1]};
                r_cnt <= r_cnt + 1'b1;
            end
            // truncating divide: apply sign to the magnitude quotient
            if (i_cmd.commit && !r_den_zero) begin
                r_bd <= r_bd + (r_nd ? -34'(r_qd) : 34'(r_qd));
                r_bs <= r_bs + (r_ns ? -34'(r_qs) : 34'(r_qs));
            end
        end
    end

    assign o_status.div_last = (r_cnt == CW'(PW - 1));
    assign o_status.tracking = r_track;
    assign o_active  = r_active;
    assign o_lockout = r_lockout;

endmodule

// ----- design/dra_ctrl.sv -----
// ----------------------------------------------------------------------------
// dra_ctrl: sequencer of the draw event detector
// Steps one request through test, then multiply and divide when tracking, and result.
// ----------------------------------------------------------------------------
module dra_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_fire,
    input  logic             i_out_fire,
    input  dra_pkg::t_status i_status,
    output dra_pkg::t_cmd    o_cmd,
    output logic             o_in_ready,
    output logic             o_out_valid
);
    import dra_pkg::*;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= ST_IDLE;
        else          r_state <= n_state;
    end

    always_comb begin
        n_state = r_state;
        o_cmd = '0;
        o_in_ready = 1'b0;
        o_out_valid = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_fire) begin
                    o_cmd.load = 1'b1;
                    n_state = ST_EVAL;
                end
            end
            ST_EVAL: begin
                if (i_status.tracking) begin
                    o_cmd.mul = 1'b1;
                    n_state = ST_MUL;
                end else begin
                    n_state = ST_OUT;
                end
            end
            ST_MUL: begin
                o_cmd.div_start = 1'b1;
                n_state = ST_DIV;
            end
            ST_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_status.div_last) begin
                    n_state = ST_OUT;
                end
            end
            ST_OUT: begin
                o_out_valid = 1'b1;
                if (i_out_fire) begin
                    o_cmd.commit = i_status.tracking;
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

endmodule

// ----- design/draw_event_detector.sv -----
// ----------------------------------------------------------------------------
// draw_event_detector: draw detection on disturbance and slope samples
// Without baseline tracking the result is offered after the test step; with
// tracking a multiply and a 49-bit restoring divide come first (one quotient
// bit per cycle, both baselines in parallel). One request at a time: no new
// request is taken until the result is taken, also while it is stalled.
// Reset is synchronous and active low; it clears flags, timers and baselines.
// ----------------------------------------------------------------------------
module draw_event_detector #(
    parameter int FRAC_BITS = dra_pkg::FRAC_BITS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    dra_stream_if.sink                 i_req,
    dra_stream_if.source               o_rsp,
    input  logic                       i_cfg_we,
    input  logic [dra_pkg::IDX_W-1:0]  i_cfg_idx,
    input  logic [dra_pkg::DATA_W-1:0] i_cfg_data
);
    import dra_pkg::*;

    // thresholds compare as plain integers; the format only sets their meaning
    localparam int ONE = 1 << FRAC_BITS;

    logic [THR_W-1:0]  r_on_drop, r_off_drop, r_slope_rise;
    logic [DATA_W-1:0] r_tau, r_on_deb, r_off_deb, r_max_draw;
    t_cmd    cmd;
    t_status status;
    logic    in_ready, out_valid, act, lck;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_on_drop    <= THR_W'(ONE);
            r_off_drop   <= THR_W'(ONE / 2);
            r_slope_rise <= THR_W'(ONE);
            r_tau        <= 32'd30000;
            r_on_deb     <= 32'd500;
            r_off_deb    <= 32'd1000;
            r_max_draw   <= 32'd60000;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_ON_DROP:    r_on_drop    <= i_cfg_data[THR_W-1:0];
                REG_OFF_DROP:   r_off_drop   <= i_cfg_data[THR_W-1:0];
                REG_SLOPE_RISE: r_slope_rise <= i_cfg_data[THR_W-1:0];
                REG_TAU:        r_tau        <= i_cfg_data;
                REG_ON_DEB:     r_on_deb     <= i_cfg_data;
                REG_OFF_DEB:    r_off_deb    <= i_cfg_data;
                REG_MAX_DRAW:   r_max_draw   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    dra_ctrl u_ctrl (
        .i_clk, .i_rst_n,
        .i_in_fire  (i_req.valid && in_ready),
        .i_out_fire (out_valid && o_rsp.ready),
        .i_status   (status),
        .o_cmd      (cmd),
        .o_in_ready (in_ready),
        .o_out_valid(out_valid)
    );

    dra_datapath u_dp (
        .i_clk, .i_rst_n,
        .i_cmd       (cmd),
        .o_status    (status),
        .i_dist      (i_req.data[80:49]),
        .i_slope     (i_req.data[48:17]),
        .i_dt        (i_req.data[16:1]),
        .i_en        (i_req.data[0]),
        .i_on_drop   (r_on_drop),
        .i_off_drop  (r_off_drop),
        .i_slope_rise(r_slope_rise),
        .i_tau       (r_tau),
        .i_on_deb    (r_on_deb),
        .i_off_deb   (r_off_deb),
        .i_max_draw  (r_max_draw),
        .o_active    (act),
        .o_lockout   (lck)
    );

    assign i_req.ready = in_ready;
    assign o_rsp.valid = out_valid;
    assign o_rsp.data  = {lck, act};

endmodule

// ----- design/dra_checker.sv -----
// ----------------------------------------------------------------------------
// dra_checker: port-level checks of the draw event detector
// Stall holds result; no draw+lockout; one request at a time; disable clears.
// ----------------------------------------------------------------------------
module dra_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        i_in_ready,
    input logic        i_in_en,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [1:0]  i_out_data
);
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_data))
        else $error("result changed under stall");
    a_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> !(i_out_data[0] && i_out_data[1]))
        else $error("draw and lockout together");
    a_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> !i_in_ready)
        else $error("request taken while result pending");
    a_dis: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready && !i_in_en |=> ##1 i_out_valid && i_out_data == 2'b00)
        else $error("disable did not clear result");
endmodule

bind draw_event_detector dra_checker u_chk (
    .i_clk, .i_rst_n,
    .i_in_valid (i_req.valid),
    .i_in_ready (i_req.ready),
    .i_in_en    (i_req.data[0]),
    .i_out_valid(o_rsp.valid),
    .i_out_ready(o_rsp.ready),
    .i_out_data (o_rsp.data)
);
